FILE: hw/rtl/mi_pkg.sv
package mi_pkg;

	// modulus after reset, cut to the word width at the top level
	localparam logic [63:0] RESET_MODULUS = 64'd1000000007;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

FILE: hw/rtl/mi_step_unit.sv
module mi_step_unit #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] dividend,
	input  logic [WORD_BITS-1:0] divisor,
	input  logic [WORD_BITS-1:0] cur,
	output logic                 done,
	output logic [WORD_BITS-1:0] rem,
	output logic [WORD_BITS-1:0] prod
);
	import mi_pkg::*;

	localparam int CW = $clog2(WORD_BITS);
	localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

	logic                 running_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] dq_q;
	logic [WORD_BITS-1:0] d_q;
	logic [WORD_BITS-1:0] c_q;
	logic [WORD_BITS-1:0] acc_q;

	logic [WORD_BITS:0]   r_shift;
	logic [WORD_BITS:0]   diff;
	logic                 qbit;
	logic [WORD_BITS-1:0] acc_next;

	// one restoring division step; quotient bits feed a horner product with cur
	always_comb begin
		r_shift  = {r_q, dq_q[WORD_BITS-1]};
		diff     = r_shift - {1'b0, d_q};
		qbit     = ~diff[WORD_BITS];
		acc_next = {acc_q[WORD_BITS-2:0], 1'b0} + (qbit ? c_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	// partial remainder stays below the divisor, so it fits in one word
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= '0;
			dq_q  <= dividend;
			d_q   <= divisor;
			c_q   <= cur;
			acc_q <= '0;
		end else if (running_q) begin
			r_q   <= qbit ? diff[WORD_BITS-1:0] : r_shift[WORD_BITS-1:0];
			dq_q  <= {dq_q[WORD_BITS-2:0], qbit};
			acc_q <= acc_next;
		end
	end

	assign done = done_q;
	assign rem  = r_q;
	assign prod = acc_q;

endmodule

FILE: hw/rtl/modular_inverse_core.sv
// modular inverse core: inverse of value modulo a programmable modulus,
// by the continued-fraction form of the extended euclidean algorithm.
//
// input beat: drive value and raise start; it is taken at the clock edge
// where start is high and busy is low. busy stays high until the result
// beat has gone out, so one item is in flight at a time.
// result beat: done is high for exactly one cycle with inverse valid;
// the receiver cannot stall, it must take the beat in that cycle.
// config: modulus_we writes modulus_wdata into the modulus register;
// write it only while busy is low.
//
// steps: each euclid step runs one pass of the shared step unit, a
// bit-serial restoring divider that also builds quotient * current
// numerator, one quotient bit a cycle. a zero value goes straight to done
// without a step. busy drops the cycle after the result beat, so a new beat
// can be taken once busy is low; with 32-bit words about 46 steps at most.
//
// reset: modulus returns to 1000000007 (cut to WORD_BITS), the sequencer
// goes idle and no result beat is pending.
module modular_inverse_core #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_BITS-1:0] value,
	output logic                 done,
	output logic [WORD_BITS-1:0] inverse,
	input  logic                 modulus_we,
	input  logic [WORD_BITS-1:0] modulus_wdata
);
	import mi_pkg::*;

	state_t state_q;
	state_t state_next;

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] dividend_q;
	logic [WORD_BITS-1:0] divisor_q;
	logic [WORD_BITS-1:0] cur_q;
	logic [WORD_BITS-1:0] prev_q;
	logic                 odd_q;

	logic                 step_start;
	logic                 step_done;
	logic [WORD_BITS-1:0] step_rem;
	logic [WORD_BITS-1:0] step_prod;
	logic                 divisor_zero;

	assign divisor_zero = (divisor_q == '0);

	// shared divide / multiply-accumulate unit
	mi_step_unit #(
		.WORD_BITS(WORD_BITS)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (step_start),
		.dividend(dividend_q),
		.divisor (divisor_q),
		.cur     (cur_q),
		.done    (step_done),
		.rem     (step_rem),
		.prod    (step_prod)
	);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_next = ST_TEST;
			end
			ST_TEST: begin
				// loop ends once the divisor reaches zero
				state_next = divisor_zero ? ST_DONE : ST_RUN;
			end
			ST_RUN: begin
				if (step_done) state_next = ST_TEST;
			end
			ST_DONE: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy       = 1'b1;
		done       = 1'b0;
		step_start = 1'b0;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_TEST: step_start = ~divisor_zero;
			ST_RUN:  busy = 1'b1;
			ST_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	// odd parity gives the last-but-one numerator, even its complement
	assign inverse = odd_q ? prev_q : (modulus_q - prev_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			modulus_q <= RESET_MODULUS[WORD_BITS-1:0];
		end else begin
			state_q <= state_next;
			if (modulus_we) modulus_q <= modulus_wdata;
		end
	end

	// euclid state; numerators kept mod 2^WORD_BITS, which is exact here
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			dividend_q <= modulus_q;
			divisor_q  <= value;
			cur_q      <= {{(WORD_BITS-1){1'b0}}, 1'b1};
			prev_q     <= '0;
			odd_q      <= 1'b0;
		end else if (state_q == ST_RUN && step_done) begin
			prev_q     <= cur_q;
			cur_q      <= step_prod + prev_q;
			dividend_q <= divisor_q;
			divisor_q  <= step_rem;
			odd_q      <= ~odd_q;
		end
	end

endmodule
